@@ design/sha256_pkg.sv @@
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int LENGTH_COUNTER_BITS = 61;

  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] INITIAL_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      byte_en;
    byte_sel_t byte_sel;
    logic      count_inc;
    logic      round_en;
    logic [5:0] rnd;
    logic      fold;
    logic      reload;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } dp_sts_t;

endpackage

@@ design/sha256_dp.sv @@
`timescale 1ns / 1ps
module sha256_dp import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_data,
  output dp_sts_t   sts,
  output out_word_t digest
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  wd [16];
  logic [5:0]   pos_r;
  logic [LENGTH_COUNTER_BITS-1:0] count_r;
  logic [31:0]  v_r [8];
  logic [31:0]  ch_r [8];
  logic [31:0]  vn [8];
  logic [31:0]  sum [8];
  logic [31:0]  new_w, t1, t2;
  logic [63:0]  len_bits, len_sh;
  logic [7:0]   byte_mux;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      wd[i] = blk_r[511-32*i -: 32];
    end
  end

  assign len_bits = 64'(count_r) << 3;
  assign len_sh   = len_bits << {pos_r[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:   byte_mux = in_data.byte_value;
      SEL_PAD80: byte_mux = PAD_BYTE;
      SEL_LEN:   byte_mux = len_sh[63:56];
      default:   byte_mux = 8'd0;
    endcase
  end

  assign new_w = ssig1(wd[14]) + wd[9] + ssig0(wd[1]) + wd[0];

  always_comb begin
    blk_nxt = blk_r;
    if (cmd.byte_en) begin
      blk_nxt = {blk_r[503:0], byte_mux};
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], new_w};
    end
  end

  always_comb begin
    t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + ROUND_K[cmd.rnd] + wd[0];
    t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    vn[0] = t1 + t2;
    vn[1] = v_r[0];
    vn[2] = v_r[1];
    vn[3] = v_r[2];
    vn[4] = v_r[3] + t1;
    vn[5] = v_r[4];
    vn[6] = v_r[5];
    vn[7] = v_r[6];
    for (int i = 0; i < 8; i++) begin
      sum[i] = ch_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.byte_en) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.reload) begin
        count_r <= '0;
      end else if (cmd.count_inc) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i]  <= INITIAL_HASH[i];
        ch_r[i] <= INITIAL_HASH[i];
      end
    end else if (cmd.round_en) begin
      v_r <= vn;
    end else if (cmd.fold) begin
      v_r  <= sum;
      ch_r <= sum;
    end else if (cmd.reload) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i]  <= INITIAL_HASH[i];
        ch_r[i] <= INITIAL_HASH[i];
      end
    end
  end

  assign sts.pos = pos_r;

  assign digest.digest_bits_255_192 = {ch_r[0], ch_r[1]};
  assign digest.digest_bits_191_128 = {ch_r[2], ch_r[3]};
  assign digest.digest_bits_127_64  = {ch_r[4], ch_r[5]};
  assign digest.digest_bits_63_0    = {ch_r[6], ch_r[7]};

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.count_inc && !cmd.reload) |=>
      count_r == LENGTH_COUNTER_BITS'($past(count_r) + 1'b1))
    else $error("Byte count did not advance by one.");

  a_no_byte_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.byte_en && cmd.round_en))
    else $error("Byte shift and round issued together.");

endmodule

@@ design/sha256_ctrl.sv @@
`timescale 1ns / 1ps
module sha256_ctrl import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output dp_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [5:0] rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    rnd_nxt       = rnd_r;
    cmd           = '0;
    cmd.byte_sel  = SEL_ZERO;
    cmd.rnd       = rnd_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.byte_present) begin
            cmd.byte_en   = 1'b1;
            cmd.byte_sel  = SEL_MSG;
            cmd.count_inc = 1'b1;
          end
          if (in_data.byte_present && sts.pos == LAST_POS) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
            ret_nxt   = in_data.end_of_message ? ST_PAD80 : ST_IDLE;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ret_r;
      end
      ST_PAD80: begin
        cmd.byte_en  = 1'b1;
        cmd.byte_sel = SEL_PAD80;
        if (sts.pos == LAST_POS) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = '0;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts.pos == LEN_POS) begin
          state_nxt = ST_PADLEN;
        end else begin
          cmd.byte_en  = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (sts.pos == LAST_POS) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
            ret_nxt   = ST_PADZ;
          end
        end
      end
      ST_PADLEN: begin
        cmd.byte_en  = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (sts.pos == LAST_POS) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = '0;
          ret_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.reload = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_ROUND) |=> state_r == ST_FOLD)
    else $error("Last round not followed by the fold step.");

  a_round_starts_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROUND && state_nxt == ST_ROUND) |-> rnd_nxt == '0)
    else $error("Compression started at a nonzero round.");

endmodule

@@ design/sha256_message_hasher.sv @@
// SHA-256 hasher that takes one message byte per word and returns the 256-bit
// digest as one word after the word marked end_of_message. While a block is
// being gathered a byte is taken every cycle; the 64th byte of a block holds
// the input stalled while the single shared round unit runs 64 rounds and
// folds the result into the chaining words. At the end of a message the
// padding bytes are shifted in one per cycle outside compression (up to 64,
// or up to 72 if more than 55 bytes of the last block are used, with a
// pause in ST_PADZ before the length bytes), each padded block again runs
// the rounds and the fold, and the digest is then held on the output until
// taken; no new word is accepted until it is. Bit length is modulo 2^64.
`timescale 1ns / 1ps
module sha256_message_hasher import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha256_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .sts     (sts),
    .digest  (out_data)
  );

  a_digest_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sts.pos == '0)
    else $error("Digest offered with a partly filled block.");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("Input open while a digest is pending.");

endmodule
